/* rtl/plo_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plo_pkg
// shared types and codes for the positional ordered list
// ----------------------------------------------------------------------------
package plo_pkg;

    // operation codes carried on the input tuser
    localparam logic [2:0] FN_INS_FRONT = 3'd0;
    localparam logic [2:0] FN_INS_BACK  = 3'd1;
    localparam logic [2:0] FN_INS_AT    = 3'd2;
    localparam logic [2:0] FN_DEL_FRONT = 3'd3;
    localparam logic [2:0] FN_DEL_BACK  = 3'd4;
    localparam logic [2:0] FN_DEL_AT    = 3'd5;
    localparam logic [2:0] FN_READ_ALL  = 3'd6;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    // most elements a single read-out returns
    localparam int MAX_READOUT = 32;

    // one result transfer
    typedef struct packed {
        logic signed [31:0] element;
        logic [4:0]         element_index;
        logic               has_element;
        logic [5:0]         list_count;
        logic [1:0]         status;
        logic               last;
    } result_t;

endpackage
`default_nettype wire

/* rtl/positional_ordered_list.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// positional_ordered_list
// bounded ordered list with insert and delete at front, back or position
// ----------------------------------------------------------------------------
// latency: an update gives its status transfer once its shift has moved every
//   element and an insert has also written its value; a refused update or an
//   unused code goes straight to its status transfer; a read-out reads its
//   elements in turn, each loaded into the output register once that is free
// throughput: one item at a time, set by the sequencer that walks the shift one
//   element per cycle through the memory port; the next item is taken once the
//   last result of the current one sits in the output register
// reset: aresetn synchronous active low, clears the count and the control
//   state; the element memory keeps its contents and needs no clearing pass
// ----------------------------------------------------------------------------
module positional_ordered_list #(
    parameter int CAPACITY    = 32,   // elements held, 2 to 63
    parameter int VALUE_WIDTH = 32    // stored value width, 8 to 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // operation channel
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    input  wire logic [39:0] s_tdata,   // value [31:0], position [37:32], zero pad
    input  wire logic [2:0]  s_tuser,   // func [2:0]
    // result channel
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    output      logic [47:0] m_tdata,   // element [31:0], element_index [36:32],
                                        // list_count [42:37], zero pad
    output      logic [2:0]  m_tuser,   // has_element [0], status [2:1]
    output      logic        m_tlast    // last result of the item
);
    import plo_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    // memory port between sequencer and store
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    logic [VALUE_WIDTH-1:0] mem_rdata;

    // result hand-off into the output register
    logic    res_load;
    result_t res;
    logic    out_free;

    // output register, parts the sequencer from the downstream side
    result_t out_reg,       out_next;
    logic    out_valid_reg, out_valid_next;

    // the register may take a new result when empty or draining this cycle
    assign out_free = !out_valid_reg || m_tready;

    plo_seq #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_func   (s_tuser),
        .in_value  ($signed(s_tdata[31:0])),
        .in_pos    (s_tdata[37:32]),
        .out_free  (out_free),
        .res_load  (res_load),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    plo_store #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_load) begin
            out_next       = res;
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            // current transfer taken, nothing new behind it
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_reg <= out_next;
    end

    // pack the result fields onto the stream
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_reg.list_count, out_reg.element_index, out_reg.element};
    assign m_tuser  = {out_reg.status, out_reg.has_element};
    assign m_tlast  = out_reg.last;

endmodule
`default_nettype wire

/* rtl/plo_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plo_store
// element memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module plo_store #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

/* rtl/plo_seq.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plo_seq
// sequencer: decodes an operation, walks the shift one element per cycle
// through the memory port and issues the result transfers
// ----------------------------------------------------------------------------
module plo_seq #(
    parameter int CAPACITY    = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output      logic                        in_ready,
    input  wire logic [2:0]                  in_func,
    input  wire logic signed [31:0]          in_value,
    input  wire logic [5:0]                  in_pos,
    input  wire logic                        out_free,
    output      logic                        res_load,
    output      plo_pkg::result_t            res,
    output      logic                        mem_we,
    output      logic [$clog2(CAPACITY)-1:0] mem_waddr,
    output      logic [VALUE_WIDTH-1:0]      mem_wdata,
    output      logic                        mem_re,
    output      logic [$clog2(CAPACITY)-1:0] mem_raddr,
    input  wire logic [VALUE_WIDTH-1:0]      mem_rdata
);
    import plo_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > 6) ? CW : 6) + 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SHIFT  = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_RWAIT  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    logic [2:0]             state_reg,  state_next;
    logic [CW-1:0]          count_reg,  count_next;
    logic [CW-1:0]          rem_reg,    rem_next;
    logic [AW-1:0]          src_reg,    src_next;
    logic [AW-1:0]          dst_reg,    dst_next;
    logic                   pend_reg,   pend_next;
    logic                   ins_reg,    ins_next;
    logic [AW-1:0]          slot_reg,   slot_next;
    logic [VALUE_WIDTH-1:0] val_reg,    val_next;
    logic [1:0]             status_reg, status_next;
    logic [CW-1:0]          rd_idx_reg, rd_idx_next;

    logic [PW-1:0] cnt_p;
    logic [PW-1:0] pos_p;
    logic [PW-1:0] p_p;
    logic [PW-1:0] n_p;
    logic          rd_last;

    assign cnt_p    = PW'(count_reg);
    assign pos_p    = PW'(in_pos);
    assign n_p      = (cnt_p > PW'(MAX_READOUT)) ? PW'(MAX_READOUT) : cnt_p;
    assign rd_last  = (PW'(rd_idx_reg) + PW'(1)) == n_p;
    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        rem_next    = rem_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        pend_next   = pend_reg;
        ins_next    = ins_reg;
        slot_next   = slot_reg;
        val_next    = val_reg;
        status_next = status_reg;
        rd_idx_next = rd_idx_reg;
        p_p         = '0;
        res_load    = 1'b0;
        res         = '0;
        mem_we      = 1'b0;
        mem_waddr   = dst_reg;
        mem_wdata   = mem_rdata;
        mem_re      = 1'b0;
        mem_raddr   = src_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next  = S_RESULT;
                    status_next = ST_OK;
                    val_next    = VALUE_WIDTH'(in_value);
                    case (in_func)
                        FN_INS_FRONT, FN_INS_BACK, FN_INS_AT: begin
                            if (in_func == FN_INS_FRONT) begin
                                p_p = '0;
                            end else if (in_func == FN_INS_BACK) begin
                                p_p = cnt_p;
                            end else begin
                                p_p = pos_p - PW'(1);
                            end
                            if (cnt_p >= PW'(CAPACITY)) begin
                                status_next = ST_FULL;
                            end else if (in_func == FN_INS_AT &&
                                         (pos_p == '0 || pos_p > cnt_p + PW'(1))) begin
                                status_next = ST_BADPOS;
                            end else begin
                                count_next = count_reg + CW'(1);
                                ins_next   = 1'b1;
                                slot_next  = AW'(p_p);
                                rem_next   = CW'(cnt_p - p_p);
                                src_next   = AW'(cnt_p - PW'(1));
                                pend_next  = 1'b0;
                                state_next = S_SHIFT;
                            end
                        end
                        FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_AT: begin
                            if (in_func == FN_DEL_FRONT) begin
                                p_p = '0;
                            end else if (in_func == FN_DEL_BACK) begin
                                p_p = cnt_p - PW'(1);
                            end else begin
                                p_p = pos_p - PW'(1);
                            end
                            if (cnt_p == '0) begin
                                status_next = ST_EMPTY;
                            end else if (in_func == FN_DEL_AT &&
                                         (pos_p == '0 || pos_p > cnt_p)) begin
                                status_next = ST_BADPOS;
                            end else begin
                                count_next = count_reg - CW'(1);
                                ins_next   = 1'b0;
                                rem_next   = CW'(cnt_p - PW'(1) - p_p);
                                src_next   = AW'(p_p + PW'(1));
                                pend_next  = 1'b0;
                                state_next = S_SHIFT;
                            end
                        end
                        FN_READ_ALL: begin
                            rd_idx_next = '0;
                            if (cnt_p != '0) begin
                                state_next = S_READ;
                            end
                        end
                        default: begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                // write back the element read last cycle
                mem_we = pend_reg;
                if (rem_reg != '0) begin
                    mem_re    = 1'b1;
                    pend_next = 1'b1;
                    rem_next  = rem_reg - CW'(1);
                    if (ins_reg) begin
                        dst_next = src_reg + AW'(1);
                        src_next = src_reg - AW'(1);
                    end else begin
                        dst_next = src_reg - AW'(1);
                        src_next = src_reg + AW'(1);
                    end
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        if (ins_reg) begin
                            mem_we    = 1'b1;
                            mem_waddr = slot_reg;
                            mem_wdata = val_reg;
                        end
                        state_next = S_RESULT;
                    end
                end
            end

            S_READ: begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(rd_idx_reg);
                state_next = S_RWAIT;
            end

            S_RWAIT: begin
                if (out_free) begin
                    res_load          = 1'b1;
                    res.element       = 32'($signed(mem_rdata));
                    res.element_index = 5'(rd_idx_reg);
                    res.has_element   = 1'b1;
                    res.list_count    = 6'(count_reg);
                    res.status        = ST_OK;
                    res.last          = rd_last;
                    rd_idx_next       = rd_idx_reg + CW'(1);
                    state_next        = rd_last ? S_IDLE : S_READ;
                end
            end

            S_RESULT: begin
                if (out_free) begin
                    res_load       = 1'b1;
                    res.list_count = 6'(count_reg);
                    res.status     = status_reg;
                    res.last       = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
        rem_reg    <= rem_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        ins_reg    <= ins_next;
        slot_reg   <= slot_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        rd_idx_reg <= rd_idx_next;
    end

endmodule
`default_nettype wire
